@@ rtl/c2s_pkg.sv @@
// shared types, constants and arctangent table for the spherical converter
`default_nettype none

package c2s_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int CORDIC_STEPS = 18;
    localparam int GUARD_BITS   = 8;
    localparam int TAB_FRAC     = 24;
    localparam int TAB_LEN      = 30;
    localparam int NSTEP        = (CORDIC_STEPS < TAB_LEN) ? CORDIC_STEPS : TAB_LEN;

    // coordinate, square and root widths
    localparam int COORD_W   = 24;
    localparam int SQ_W      = 2 * COORD_W;
    localparam int PG_N_W    = SQ_W + 2 * GUARD_BITS;
    localparam int PG_STEPS  = PG_N_W / 2;
    localparam int RHO_STEPS = SQ_W / 2;

    // cordic datapath and angle accumulator widths
    localparam int CW    = 36;
    localparam int ANG_W = 34;
    localparam int ASH   = TAB_FRAC - FRAC_BITS;

    localparam int AZ_W = 25;
    localparam int EL_W = 24;
    localparam int RD_W = 24;

    typedef logic signed [ANG_W-1:0] ang_t;
    typedef logic signed [CW-1:0]    cval_t;

    localparam ang_t FULL90_OUT = ang_t'(64'sd90 << FRAC_BITS);
    localparam ang_t FULL90_TAB = ang_t'(64'sd90 << TAB_FRAC);
    localparam ang_t FULL360_OUT = ang_t'(64'sd360 << FRAC_BITS);
    localparam ang_t HALF_OUT   = (ASH > 0) ? ang_t'(64'sd1 << (ASH - 1)) : ang_t'(0);

    // information that travels beside the datapath
    typedef struct packed {
        logic                        zero;
        logic                        xy0;
        logic signed [COORD_W-1:0]   x;
        logic signed [COORD_W-1:0]   y;
        logic signed [COORD_W-1:0]   z;
    } c2s_side_t;

    // arctangent of 2^-i in 2^-24 degree
    function automatic ang_t atan_tab(input int idx);
        ang_t v;
        v = '0;
        case (idx)
            0:  v = ang_t'(754974720);
            1:  v = ang_t'(445687602);
            2:  v = ang_t'(235489088);
            3:  v = ang_t'(119537938);
            4:  v = ang_t'(60000934);
            5:  v = ang_t'(30029717);
            6:  v = ang_t'(15018523);
            7:  v = ang_t'(7509720);
            8:  v = ang_t'(3754917);
            9:  v = ang_t'(1877466);
            10: v = ang_t'(938734);
            11: v = ang_t'(469367);
            12: v = ang_t'(234684);
            13: v = ang_t'(117342);
            14: v = ang_t'(58671);
            15: v = ang_t'(29335);
            16: v = ang_t'(14668);
            17: v = ang_t'(7334);
            18: v = ang_t'(3667);
            19: v = ang_t'(1833);
            20: v = ang_t'(917);
            21: v = ang_t'(458);
            22: v = ang_t'(229);
            23: v = ang_t'(115);
            24: v = ang_t'(57);
            25: v = ang_t'(29);
            26: v = ang_t'(14);
            27: v = ang_t'(7);
            28: v = ang_t'(4);
            29: v = ang_t'(2);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

@@ rtl/cartesian_to_spherical.sv @@
// cartesian to spherical converter: squares, bit-serial roots, unrolled cordic pipeline
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  input   | in_valid, in_ready, coord_x/y/z           | in
//  output  | out_valid, out_ready, azimuth, elevation, | out
//          | radius, zero_vector                       |
//
// one transaction per cycle while the pipeline is not held; the path runs through the input, squares
// and sums registers, the one-bit-per-stage square roots, the cordic setup, the unrolled
// cordic stages and the output register.
// reset clears only the valid bits; the whole pipeline holds when the output
// stage is full and out_ready is low, so nothing is dropped or repeated.
`default_nettype none

module cartesian_to_spherical (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic signed [c2s_pkg::COORD_W-1:0]    coord_x,
    input  wire logic signed [c2s_pkg::COORD_W-1:0]    coord_y,
    input  wire logic signed [c2s_pkg::COORD_W-1:0]    coord_z,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic [c2s_pkg::AZ_W-1:0]                   azimuth,
    output logic signed [c2s_pkg::EL_W-1:0]            elevation,
    output logic [c2s_pkg::RD_W-1:0]                   radius,
    output logic                                       zero_vector
);
    import c2s_pkg::*;

    localparam int NSQ = PG_STEPS;

    logic en;

    // input stage
    logic                      a_vld_reg;
    logic signed [COORD_W-1:0] a_x_reg, a_y_reg, a_z_reg;

    // squares stage
    logic                      b_vld_reg;
    logic [SQ_W-1:0]           b_sx_reg, b_sy_reg, b_sz_reg;
    c2s_side_t                 b_side_reg;

    // square root pipeline, index 0 is the sums stage
    logic                      q_vld_reg  [0:NSQ];
    c2s_side_t                 q_side_reg [0:NSQ];
    logic [PG_N_W-1:0]         q_pn_reg   [0:NSQ];
    logic [PG_STEPS-1:0]       q_pr_reg   [0:NSQ];
    logic [PG_STEPS+1:0]       q_prem_reg [0:NSQ];
    logic [SQ_W-1:0]           q_rn_reg   [0:NSQ];
    logic [RHO_STEPS-1:0]      q_rr_reg   [0:NSQ];
    logic [RHO_STEPS+1:0]      q_rrem_reg [0:NSQ];

    // cordic pipeline, index 0 is the setup stage
    logic                      c_vld_reg  [0:NSTEP];
    c2s_side_t                 c_side_reg [0:NSTEP];
    logic [RD_W-1:0]           c_rho_reg  [0:NSTEP];
    cval_t                     c_aa_reg   [0:NSTEP];
    cval_t                     c_ab_reg   [0:NSTEP];
    ang_t                      c_aacc_reg [0:NSTEP];
    cval_t                     c_pa_reg   [0:NSTEP];
    cval_t                     c_pb_reg   [0:NSTEP];
    ang_t                      c_pacc_reg [0:NSTEP];

    // output stage
    logic                      o_vld_reg;
    logic [AZ_W-1:0]           o_az_reg;
    logic signed [EL_W-1:0]    o_el_reg;
    logic [RD_W-1:0]           o_rd_reg;
    logic                      o_zero_reg;

    // global advance: move when the output stage is empty or being taken
    assign en        = !o_vld_reg || out_ready;
    assign in_ready  = en;
    assign out_valid = o_vld_reg;
    assign azimuth     = o_az_reg;
    assign elevation   = o_el_reg;
    assign radius      = o_rd_reg;
    assign zero_vector = o_zero_reg;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            a_vld_reg <= in_valid;
            b_vld_reg <= a_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_x_reg <= coord_x;
            a_y_reg <= coord_y;
            a_z_reg <= coord_z;
        end
    end

    // full-width signed products of the coordinates
    logic signed [SQ_W-1:0] sq_x, sq_y, sq_z;

    always_comb
    begin
        sq_x = a_x_reg * a_x_reg;
        sq_y = a_y_reg * a_y_reg;
        sq_z = a_z_reg * a_z_reg;
    end

    // squares
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_sx_reg        <= unsigned'(sq_x);
            b_sy_reg        <= unsigned'(sq_y);
            b_sz_reg        <= unsigned'(sq_z);
            b_side_reg.zero <= 1'b0;
            b_side_reg.xy0  <= 1'b0;
            b_side_reg.x    <= a_x_reg;
            b_side_reg.y    <= a_y_reg;
            b_side_reg.z    <= a_z_reg;
        end
    end

    // sums and root initialisation
    logic [SQ_W-1:0] sum_xy, sum_all;
    c2s_side_t       side0;

    always_comb
    begin
        sum_xy     = b_sx_reg + b_sy_reg;
        sum_all    = sum_xy + b_sz_reg;
        side0      = b_side_reg;
        side0.zero = (sum_all == '0);
        side0.xy0  = (sum_xy == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            q_vld_reg[0] <= 1'b0;
        else if (en)
            q_vld_reg[0] <= b_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_side_reg[0] <= side0;
            q_pn_reg[0]   <= {sum_xy, (2 * GUARD_BITS)'(0)};
            q_pr_reg[0]   <= '0;
            q_prem_reg[0] <= '0;
            q_rn_reg[0]   <= sum_all;
            q_rr_reg[0]   <= '0;
            q_rrem_reg[0] <= '0;
        end
    end

    // one root bit per stage for both roots; the radius root is held after its RHO_STEPS stages
    genvar k;
    generate
        for (k = 0; k < NSQ; k++)
        begin : g_sqrt
            logic [PG_STEPS+3:0]  p_trial;
            logic [RHO_STEPS+3:0] r_trial;
            logic [PG_STEPS-1:0]  p_r_next;
            logic [PG_STEPS+1:0]  p_rem_next;
            logic [RHO_STEPS-1:0] r_r_next;
            logic [RHO_STEPS+1:0] r_rem_next;

            always_comb
            begin
                p_trial = {q_prem_reg[k], q_pn_reg[k][PG_N_W-1 -: 2]}
                        - {2'b00, q_pr_reg[k], 2'b01};
                if (!p_trial[PG_STEPS+3])
                begin
                    p_rem_next = p_trial[PG_STEPS+1:0];
                    p_r_next   = {q_pr_reg[k][PG_STEPS-2:0], 1'b1};
                end
                else
                begin
                    p_rem_next = {q_prem_reg[k][PG_STEPS-1:0], q_pn_reg[k][PG_N_W-1 -: 2]};
                    p_r_next   = {q_pr_reg[k][PG_STEPS-2:0], 1'b0};
                end

                r_trial = {q_rrem_reg[k], q_rn_reg[k][SQ_W-1 -: 2]}
                        - {2'b00, q_rr_reg[k], 2'b01};
                if (k >= RHO_STEPS)
                begin
                    r_rem_next = q_rrem_reg[k];
                    r_r_next   = q_rr_reg[k];
                end
                else if (!r_trial[RHO_STEPS+3])
                begin
                    r_rem_next = r_trial[RHO_STEPS+1:0];
                    r_r_next   = {q_rr_reg[k][RHO_STEPS-2:0], 1'b1};
                end
                else
                begin
                    r_rem_next = {q_rrem_reg[k][RHO_STEPS-1:0], q_rn_reg[k][SQ_W-1 -: 2]};
                    r_r_next   = {q_rr_reg[k][RHO_STEPS-2:0], 1'b0};
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    q_vld_reg[k+1] <= 1'b0;
                else if (en)
                    q_vld_reg[k+1] <= q_vld_reg[k];
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    q_side_reg[k+1] <= q_side_reg[k];
                    q_pn_reg[k+1]   <= {q_pn_reg[k][PG_N_W-3:0], 2'b00};
                    q_pr_reg[k+1]   <= p_r_next;
                    q_prem_reg[k+1] <= p_rem_next;
                    q_rn_reg[k+1]   <= {q_rn_reg[k][SQ_W-3:0], 2'b00};
                    q_rr_reg[k+1]   <= r_r_next;
                    q_rrem_reg[k+1] <= r_rem_next;
                end
            end
        end
    endgenerate

    // cordic setup: radius rounding and start vectors
    c2s_side_t sd;
    cval_t     xs, ys, zs;
    cval_t     s_aa, s_ab, s_pa;
    ang_t      s_aacc;
    logic [RD_W-1:0] s_rho;

    always_comb
    begin
        sd = q_side_reg[NSQ];
        xs = cval_t'(sd.x) <<< GUARD_BITS;
        ys = cval_t'(sd.y) <<< GUARD_BITS;
        zs = cval_t'(sd.z) <<< GUARD_BITS;
        s_pa = cval_t'({1'b0, q_pr_reg[NSQ]});
        if ({2'b00, q_rrem_reg[NSQ]} > {4'b0000, q_rr_reg[NSQ]})
            s_rho = q_rr_reg[NSQ] + 1'b1;
        else
            s_rho = q_rr_reg[NSQ];
        if (sd.x < 0)
        begin
            if (sd.y > 0)
            begin
                s_aa   = ys;
                s_ab   = -xs;
                s_aacc = FULL90_TAB;
            end
            else
            begin
                s_aa   = -ys;
                s_ab   = xs;
                s_aacc = -FULL90_TAB;
            end
        end
        else
        begin
            s_aa   = xs;
            s_ab   = ys;
            s_aacc = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_vld_reg[0] <= 1'b0;
        else if (en)
            c_vld_reg[0] <= q_vld_reg[NSQ];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_side_reg[0] <= sd;
            c_rho_reg[0]  <= s_rho;
            c_aa_reg[0]   <= s_aa;
            c_ab_reg[0]   <= s_ab;
            c_aacc_reg[0] <= s_aacc;
            c_pa_reg[0]   <= s_pa;
            c_pb_reg[0]   <= zs;
            c_pacc_reg[0] <= '0;
        end
    end

    // one cordic rotation per stage for azimuth and elevation
    genvar i;
    generate
        for (i = 0; i < NSTEP; i++)
        begin : g_cordic
            cval_t a_da, a_db, p_da, p_db;
            cval_t a_a_n, a_b_n, p_a_n, p_b_n;
            ang_t  a_acc_n, p_acc_n;

            always_comb
            begin
                a_da = c_ab_reg[i] >>> i;
                a_db = c_aa_reg[i] >>> i;
                p_da = c_pb_reg[i] >>> i;
                p_db = c_pa_reg[i] >>> i;
                if (c_ab_reg[i] > 0)
                begin
                    a_a_n   = c_aa_reg[i] + a_da;
                    a_b_n   = c_ab_reg[i] - a_db;
                    a_acc_n = c_aacc_reg[i] + atan_tab(i);
                end
                else
                begin
                    a_a_n   = c_aa_reg[i] - a_da;
                    a_b_n   = c_ab_reg[i] + a_db;
                    a_acc_n = c_aacc_reg[i] - atan_tab(i);
                end
                if (c_pb_reg[i] > 0)
                begin
                    p_a_n   = c_pa_reg[i] + p_da;
                    p_b_n   = c_pb_reg[i] - p_db;
                    p_acc_n = c_pacc_reg[i] + atan_tab(i);
                end
                else
                begin
                    p_a_n   = c_pa_reg[i] - p_da;
                    p_b_n   = c_pb_reg[i] + p_db;
                    p_acc_n = c_pacc_reg[i] - atan_tab(i);
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    c_vld_reg[i+1] <= 1'b0;
                else if (en)
                    c_vld_reg[i+1] <= c_vld_reg[i];
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    c_side_reg[i+1] <= c_side_reg[i];
                    c_rho_reg[i+1]  <= c_rho_reg[i];
                    c_aa_reg[i+1]   <= a_a_n;
                    c_ab_reg[i+1]   <= a_b_n;
                    c_aacc_reg[i+1] <= a_acc_n;
                    c_pa_reg[i+1]   <= p_a_n;
                    c_pb_reg[i+1]   <= p_b_n;
                    c_pacc_reg[i+1] <= p_acc_n;
                end
            end
        end
    endgenerate

    // angle rounding, clamping and special cases
    c2s_side_t fs;
    ang_t      a_abs, a_ang, phi, theta;
    logic [AZ_W-1:0]        az_next;
    logic signed [EL_W-1:0] el_next;
    logic [RD_W-1:0]        rd_next;

    always_comb
    begin
        fs    = c_side_reg[NSTEP];
        a_abs = (c_aacc_reg[NSTEP] < 0) ? -c_aacc_reg[NSTEP] : c_aacc_reg[NSTEP];
        a_ang = (a_abs + HALF_OUT) >>> ASH;
        if (a_ang > (FULL90_OUT <<< 1))
            a_ang = FULL90_OUT <<< 1;
        if (fs.y == '0)
            a_ang = (fs.x > 0) ? ang_t'(0) : (FULL90_OUT <<< 1);
        theta = (fs.y > 0) ? (FULL360_OUT - a_ang) : a_ang;

        phi = (c_pacc_reg[NSTEP] + HALF_OUT) >>> ASH;
        if (phi > FULL90_OUT)
            phi = FULL90_OUT;
        if (phi < -FULL90_OUT)
            phi = -FULL90_OUT;

        if (fs.xy0)
        begin
            theta = '0;
            phi   = (fs.z > 0) ? FULL90_OUT : -FULL90_OUT;
        end

        az_next = theta[AZ_W-1:0];
        el_next = phi[EL_W-1:0];
        rd_next = c_rho_reg[NSTEP];
        if (fs.zero)
        begin
            az_next = '0;
            el_next = '0;
            rd_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            o_vld_reg <= 1'b0;
        else if (en)
            o_vld_reg <= c_vld_reg[NSTEP];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            o_az_reg   <= az_next;
            o_el_reg   <= el_next;
            o_rd_reg   <= rd_next;
            o_zero_reg <= fs.zero;
        end
    end

endmodule

`default_nettype wire

@@ sim/testbench.sv @@
// self-checking testbench for the cartesian to spherical converter
`default_nettype none

module testbench;

    import c2s_pkg::*;

    localparam int LATENCY     = 3 + PG_STEPS + 1 + NSTEP + 1;
    localparam int N_RANDOM    = 900;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic [23:0] CMAX = 24'h7FFFFF;
    localparam logic [23:0] CMIN = 24'h800000;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } point_t;

    typedef struct packed {
        logic [AZ_W-1:0]        az;
        logic signed [EL_W-1:0] el;
        logic [RD_W-1:0]        rd;
        logic                   zv;
    } sph_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [COORD_W-1:0] coord_x = '0;
    logic signed [COORD_W-1:0] coord_y = '0;
    logic signed [COORD_W-1:0] coord_z = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [AZ_W-1:0] azimuth;
    logic signed [EL_W-1:0] elevation;
    logic [RD_W-1:0] radius;
    logic zero_vector;

    point_t pending_points[$];
    sph_t   expected_sph[$];
    int     fail_count = 0;
    int     cycle_count = 0;
    int     points_sent = 0;
    int     results_seen = 0;
    bit     stimulus_done = 0;

    cartesian_to_spherical dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
        .out_valid(out_valid), .out_ready(out_ready),
        .azimuth(azimuth), .elevation(elevation),
        .radius(radius), .zero_vector(zero_vector)
    );

    always #1 clk = ~clk;

    // arctangent of 2^-i in 2^-24 degree
    function automatic longint atan_deg(input int i);
        longint tab[30] = '{754974720, 445687602, 235489088, 119537938, 60000934,
            30029717, 15018523, 7509720, 3754917, 1877466, 938734, 469367,
            234684, 117342, 58671, 29335, 14668, 7334, 3667, 1833, 917, 458,
            229, 115, 57, 29, 14, 7, 4, 2};
        return tab[i];
    endfunction

    // floor square root, remainder returned through rem
    function automatic longint unsigned floor_root(input longint unsigned n,
                                                   output longint unsigned rem);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n)
            b >>= 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        rem = n;
        return r;
    endfunction

    // cordic vectoring towards b = 0, angle sum in 2^-24 degree
    function automatic longint rotate_to_axis(input longint a, input longint b,
                                              input longint acc);
        longint da, db;
        for (int i = 0; i < NSTEP; i++)
        begin
            da = b >>> i;
            db = a >>> i;
            if (b > 0)
            begin
                a += da; b -= db; acc += atan_deg(i);
            end
            else
            begin
                a -= da; b += db; acc -= atan_deg(i);
            end
        end
        return acc;
    endfunction

    function automatic longint round_angle(input longint acc);
        longint half;
        half = (ASH > 0) ? (64'sd1 <<< (ASH - 1)) : 0;
        return (acc + half) >>> ASH;
    endfunction

    function automatic sph_t spherical_of(input point_t p);
        longint x, y, z, full90, theta, phi, a_ang, acc;
        longint unsigned sq_xy, sq_all, rem, rho, pg;
        sph_t s;
        x = p.x; y = p.y; z = p.z;
        full90 = 64'sd90 <<< FRAC_BITS;
        sq_xy = x * x + y * y;
        sq_all = sq_xy + z * z;
        s = '0;
        if (sq_all == 0)
        begin
            s.zv = 1'b1;
            return s;
        end
        rho = floor_root(sq_all, rem);
        if (rem > rho)
            rho++;
        if (sq_xy == 0)
        begin
            theta = 0;
            phi = z > 0 ? full90 : -full90;
        end
        else
        begin
            pg = floor_root(sq_xy << (2 * GUARD_BITS), rem);
            if (y == 0)
                a_ang = x > 0 ? 0 : 2 * full90;
            else
            begin
                if (x < 0)
                    acc = y > 0 ? rotate_to_axis(y <<< 8, -(x <<< 8), 64'sd90 <<< TAB_FRAC)
                                : rotate_to_axis(-(y <<< 8), x <<< 8, -(64'sd90 <<< TAB_FRAC));
                else
                    acc = rotate_to_axis(x <<< 8, y <<< 8, 0);
                a_ang = round_angle(acc < 0 ? -acc : acc);
                if (a_ang > 2 * full90)
                    a_ang = 2 * full90;
            end
            theta = y > 0 ? (64'sd360 <<< FRAC_BITS) - a_ang : a_ang;
            phi = round_angle(rotate_to_axis(longint'(pg), z <<< 8, 0));
            if (phi > full90) phi = full90;
            if (phi < -full90) phi = -full90;
        end
        s.az = theta[AZ_W-1:0];
        s.el = phi[EL_W-1:0];
        s.rd = rho[RD_W-1:0];
        return s;
    endfunction

    function automatic logic [23:0] any_coord();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 3) == 0 ? 24'd0 : CMAX;
            1: return CMIN;
            2: return 24'($signed($urandom_range(0, 511)) - 256);
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic add_point(input logic [23:0] x, input logic [23:0] y, input logic [23:0] z);
        point_t p;
        p.x = x; p.y = y; p.z = z;
        pending_points.push_back(p);
    endtask

    // directed corners, then random points
    initial
    begin
        add_point(0, 0, 0);
        add_point(0, 0, 24'd5);
        add_point(0, 0, -24'sd5);
        add_point(0, 0, CMIN);
        add_point(24'd65536, 0, 0);
        add_point(-24'sd65536, 0, 0);
        add_point(0, 24'd1, 0);
        add_point(0, -24'sd1, 0);
        add_point(24'd1000000, 24'd1, 0);
        add_point(CMAX, CMAX, CMAX);
        add_point(CMIN, CMIN, CMIN);
        add_point(CMAX, CMIN, CMAX);
        add_point(CMIN, CMAX, CMIN);
        add_point(-24'sd3, 24'd7, -24'sd9);
        add_point(24'd1, 24'd1, 24'd1);
        add_point(-24'sd1, -24'sd1, CMAX);
        add_point(24'd1, 0, CMIN);
        add_point(24'hFFFFFF, 24'h555555, 24'hAAAAAA);
        for (int i = 0; i < N_RANDOM; i++)
            add_point(any_coord(), any_coord(), any_coord());
        stimulus_done = 1;
    end

    // reset release; the cycle counter runs in the driver
    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
    end

    // idling: random pauses for driver and output, suppressed inside a cycle_count window
    function automatic bit take_a_break();
        return !(cycle_count >= 300 && cycle_count < 900) && $urandom_range(0, 99) < 27;
    endfunction

    // driver
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                expected_sph.push_back(spherical_of({coord_x, coord_y, coord_z}));
                points_sent <= points_sent + 1;
            end
            if (!in_valid || in_ready)
            begin
                if (pending_points.size() != 0 && !take_a_break())
                begin
                    point_t p;
                    p = pending_points.pop_front();
                    in_valid <= 1'b1;
                    coord_x <= p.x; coord_y <= p.y; coord_z <= p.z;
                end
                else
                    in_valid <= 1'b0;
            end
            out_ready <= !take_a_break();
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            sph_t want;
            results_seen <= results_seen + 1;
            if (expected_sph.size() == 0)
            begin
                $display("%0t: result with nothing expected az=%0d", $time, azimuth);
                fail_count <= fail_count + 1;
            end
            else
            begin
                want = expected_sph.pop_front();
                if (want.az !== azimuth || want.el !== elevation ||
                    want.rd !== radius || want.zv !== zero_vector)
                begin
                    $display("%0t: mismatch expected az=%0d el=%0d rd=%0d zv=%0d actual az=%0d el=%0d rd=%0d zv=%0d",
                             $time, want.az, want.el, want.rd, want.zv,
                             azimuth, elevation, radius, zero_vector);
                    fail_count <= fail_count + 1;
                end
            end
        end
    end

    // end of run
    initial
    begin
        wait (rst_n);
        while (!(stimulus_done && pending_points.size() == 0 && !in_valid &&
                 expected_sph.size() == 0) && cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        $display("covered %0d points and checked %0d spherical results", points_sent,
                 results_seen);
        $display("including zero vector, axis, extreme and random coordinates");
        if (fail_count == 0 && cycle_count < CYCLE_LIMIT && expected_sph.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire

@@ filelist.f @@
rtl/c2s_pkg.sv
rtl/cartesian_to_spherical.sv
sim/testbench.sv
